@@ rtl/core/poc_pkg.sv @@
package poc_pkg;

   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 32;
   localparam int CMD_W   = 2;

   localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EOW     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_EOT     = 2'd3;

   typedef struct packed {
      logic pat_shift;
      logic txt_shift;
      logic clear;
   } poc_ctl_type;

endpackage

@@ rtl/core/poc_cell.sv @@
module poc_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  poc_pkg::poc_ctl_type      ctl,
   input  logic [poc_pkg::CHAR_W-1:0] pat_in,
   input  logic                      act_in,
   input  logic [poc_pkg::CHAR_W-1:0] txt_in,
   output logic [poc_pkg::CHAR_W-1:0] pat_out,
   output logic                      act_out,
   output logic [poc_pkg::CHAR_W-1:0] txt_out,
   output logic                      ok
);

   logic [poc_pkg::CHAR_W-1:0] pat_ff;
   logic [poc_pkg::CHAR_W-1:0] txt_ff;
   logic                       act_ff;

   // pattern byte here lines up with the window byte about to enter this cell
   always_ff @(posedge clock) begin
      if (ctl.pat_shift) begin
         pat_ff <= pat_in;
      end
      if (ctl.txt_shift) begin
         txt_ff <= txt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         act_ff <= 1'b0;
      end else if (ctl.pat_shift) begin
         act_ff <= act_in;
      end
   end

   // compare against the byte about to enter this cell
   assign ok      = !act_ff || (txt_in == pat_ff);
   assign pat_out = pat_ff;
   assign act_out = act_ff;
   assign txt_out = txt_ff;

endmodule

@@ rtl/core/pattern_occurrence_counter.sv @@
// the result appears in the cycle after the end-of-text transaction is accepted
// throughput: one transaction per cycle; each cell compares one window byte in parallel
// an end-of-text transaction waits only while an earlier result is held by rsp_ready low
// the match is a combinational and over all cells feeding a saturating 32-bit increment
// reset clears pattern length, word fill, overflow, count and the result valid flag
// end of text returns pattern length, word fill, overflow and count to reset values as the result is loaded
module pattern_occurrence_counter #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [poc_pkg::CMD_W-1:0]     req_command,
   input  logic [poc_pkg::CHAR_W-1:0]    req_char_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [poc_pkg::COUNT_W-1:0]   rsp_occurrences,
   output logic                          rsp_pattern_overflow
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

   logic [LEN_W-1:0]              plen_ff, plen_in;
   logic [LEN_W-1:0]              fill_ff, fill_in, fill_next;
   logic                          ovf_ff, ovf_in;
   logic [poc_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          rsp_valid_ff;
   logic [poc_pkg::COUNT_W-1:0]   rsp_occ_ff;
   logic                          rsp_ovf_ff;

   logic                          accept;
   logic                          do_count;
   logic                          all_ok;
   poc_pkg::poc_ctl_type          ctl;

   logic [poc_pkg::CHAR_W-1:0]    pat_chain [0:MAX_PATTERN];
   logic [poc_pkg::CHAR_W-1:0]    txt_chain [0:MAX_PATTERN];
   logic                          act_chain [0:MAX_PATTERN];
   logic [MAX_PATTERN-1:0]        ok_vec;

   // only an end-of-text transaction needs the output register
   assign req_ready = rsp_ready || !rsp_valid_ff || (req_command != poc_pkg::CMD_EOT);
   assign accept    = req_valid && req_ready;

   assign ctl.pat_shift = accept && (req_command == poc_pkg::CMD_PATTERN) && (plen_ff != LEN_MAX);
   assign ctl.txt_shift = accept && (req_command == poc_pkg::CMD_TEXT);
   assign ctl.clear     = accept && (req_command == poc_pkg::CMD_EOT);

   assign pat_chain[0] = req_char_in;
   assign txt_chain[0] = req_char_in;
   assign act_chain[0] = 1'b1;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      poc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .pat_in  (pat_chain[k]),
         .act_in  (act_chain[k]),
         .txt_in  (txt_chain[k]),
         .pat_out (pat_chain[k+1]),
         .act_out (act_chain[k+1]),
         .txt_out (txt_chain[k+1]),
         .ok      (ok_vec[k])
      );
   end

   assign all_ok    = &ok_vec;
   assign fill_next = (fill_ff == LEN_MAX) ? fill_ff : fill_ff + LEN_W'(1);

   always_comb begin
      plen_in  = plen_ff;
      fill_in  = fill_ff;
      ovf_in   = ovf_ff;
      do_count = 1'b0;
      if (accept) begin
         case (req_command)
            poc_pkg::CMD_PATTERN: begin
               if (plen_ff != LEN_MAX) begin
                  plen_in = plen_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            poc_pkg::CMD_TEXT: begin
               fill_in = fill_next;
               if (!ovf_ff) begin
                  if (plen_ff == '0) begin
                     do_count = 1'b1;
                  end else if ((fill_next >= plen_ff) && all_ok) begin
                     do_count = 1'b1;
                  end
               end
            end
            poc_pkg::CMD_EOW: begin
               fill_in  = '0;
               do_count = !ovf_ff && (plen_ff == '0);
            end
            poc_pkg::CMD_EOT: begin
               plen_in = '0;
               fill_in = '0;
               ovf_in  = 1'b0;
            end
            default: begin
               plen_in = plen_ff;
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (do_count && (count_ff != '1)) begin
         count_in = count_ff + poc_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff  <= '0;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         plen_ff  <= plen_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         rsp_occ_ff <= count_ff;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_occurrences      = rsp_occ_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

endmodule

@@ rtl/core/poc_checker.sv @@
module poc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [poc_pkg::CMD_W-1:0]   req_command,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [poc_pkg::COUNT_W-1:0] rsp_occurrences,
   input logic                        rsp_pattern_overflow
);

   logic acc_eot;
   assign acc_eot = req_valid && req_ready && (req_command == poc_pkg::CMD_EOT);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_occurrences)
         && $stable(rsp_pattern_overflow))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_eot_result: assert property (@(posedge clock) disable iff (reset)
      acc_eot |=> rsp_valid)
      else $error("end of text gave no result");

   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(acc_eot))
      else $error("result without end of text");

   // back to back end of text sees freshly cleared state
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      acc_eot ##1 acc_eot |=> (rsp_occurrences == '0) && !rsp_pattern_overflow)
      else $error("state not cleared after end of text");

endmodule

bind pattern_occurrence_counter poc_checker u_poc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_command          (req_command),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_occurrences      (rsp_occurrences),
   .rsp_pattern_overflow (rsp_pattern_overflow)
);

@@ tb/tb_pattern_occurrence_counter.sv @@
`timescale 1ns / 1ps

module tb_pattern_occurrence_counter;

   localparam int MAX_PAT    = 16;
   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE     = 8;

   typedef struct packed {
      logic [poc_pkg::CMD_W-1:0]  cmd;
      logic [poc_pkg::CHAR_W-1:0] ch;
   } stream_item_type;

   typedef struct packed {
      logic [poc_pkg::COUNT_W-1:0] occurrences;
      logic                        overflow;
   } occurrence_total_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [poc_pkg::CMD_W-1:0]    req_command = poc_pkg::CMD_PATTERN;
   logic [poc_pkg::CHAR_W-1:0]   req_char_in = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [poc_pkg::COUNT_W-1:0]  rsp_occurrences;
   logic                         rsp_pattern_overflow;

   pattern_occurrence_counter uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_char_in          (req_char_in),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_occurrences      (rsp_occurrences),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

   always #5 clock = ~clock;

   // stimulus and expected totals
   stream_item_type      pending_items[$];
   occurrence_total_type expected_totals[$];
   int                   total_items = 1;
   int                   n_text_ends = 0;
   int                   n_accepted = 0;
   int                   n_results = 0;
   int                   n_mismatch = 0;
   int                   idle_cycles = 0;

   // shadow state of the counter
   logic [poc_pkg::CHAR_W-1:0]  pat_bytes[MAX_PAT];
   logic [poc_pkg::CHAR_W-1:0]  recent_chars[MAX_PAT];
   int                          pat_len;
   int                          word_len;
   logic                        pat_overrun;
   logic [poc_pkg::COUNT_W-1:0] tally;

   task automatic clear_counter();
      for (int k = 0; k < MAX_PAT; k++) begin
         pat_bytes[k]    = '0;
         recent_chars[k] = '0;
      end
      pat_len     = 0;
      word_len    = 0;
      pat_overrun = 1'b0;
      tally       = '0;
   endtask

   task automatic count_transaction(input logic [poc_pkg::CMD_W-1:0] cmd,
                                    input logic [poc_pkg::CHAR_W-1:0] ch);
      occurrence_total_type res;
      logic                 hit;
      case (cmd)
         poc_pkg::CMD_PATTERN: begin
            if (pat_len < MAX_PAT) begin
               pat_bytes[pat_len] = ch;
               pat_len++;
            end else begin
               pat_overrun = 1'b1;
            end
         end
         poc_pkg::CMD_TEXT: begin
            for (int k = MAX_PAT - 1; k > 0; k--) recent_chars[k] = recent_chars[k-1];
            recent_chars[0] = ch;
            if (word_len < MAX_PAT) word_len++;
            if (!pat_overrun) begin
               hit = (word_len >= pat_len);
               // newest window byte lines up with the last pattern byte
               for (int j = 0; j < pat_len; j++)
                  if (recent_chars[pat_len-1-j] != pat_bytes[j]) hit = 1'b0;
               if (hit && tally != '1) tally++;
            end
         end
         poc_pkg::CMD_EOW: begin
            if (!pat_overrun && pat_len == 0 && tally != '1) tally++;
            word_len = 0;
         end
         default: begin
            res.occurrences = tally;
            res.overflow    = pat_overrun;
            expected_totals.push_back(res);
            clear_counter();
         end
      endcase
   endtask

   task automatic push_item(input logic [poc_pkg::CMD_W-1:0] cmd,
                            input logic [poc_pkg::CHAR_W-1:0] ch);
      stream_item_type it;
      it.cmd = cmd;
      it.ch  = ch;
      pending_items.push_back(it);
      if (cmd == poc_pkg::CMD_EOT) n_text_ends++;
   endtask

   // one pattern followed by a few words; some sessions are plain noise
   task automatic add_session();
      logic [poc_pkg::CHAR_W-1:0] pat[$];
      logic [poc_pkg::CHAR_W-1:0] alpha[2];
      logic [poc_pkg::CHAR_W-1:0] c;
      int                         r;
      int                         plen;
      int                         nwords;
      int                         wlen;
      r = $urandom_range(9);
      if (r == 0) begin
         repeat ($urandom_range(1, 8))
            push_item(poc_pkg::CMD_W'($urandom_range(3)), poc_pkg::CHAR_W'($urandom));
         return;
      end
      alpha[0] = poc_pkg::CHAR_W'($urandom);
      alpha[1] = poc_pkg::CHAR_W'($urandom);
      r = $urandom_range(19);
      if (r < 3) plen = 0;
      else if (r < 15) plen = $urandom_range(1, 4);
      else if (r < 18) plen = $urandom_range(5, MAX_PAT);
      else plen = $urandom_range(MAX_PAT + 1, MAX_PAT + 3);
      for (int k = 0; k < plen; k++) begin
         c = ($urandom_range(7) == 0) ? poc_pkg::CHAR_W'($urandom) : alpha[$urandom_range(1)];
         pat.push_back(c);
         push_item(poc_pkg::CMD_PATTERN, c);
      end
      nwords = $urandom_range(1, 3);
      for (int w = 0; w < nwords; w++) begin
         if (pat.size() > 0 && $urandom_range(2) == 0) begin
            // plant the pattern, sometimes twice for overlap
            repeat ($urandom_range(0, 2)) push_item(poc_pkg::CMD_TEXT, alpha[$urandom_range(1)]);
            repeat ($urandom_range(1, 2))
               for (int k = 0; k < pat.size() && k < MAX_PAT; k++)
                  push_item(poc_pkg::CMD_TEXT, pat[k]);
         end else begin
            wlen = $urandom_range(0, 8);
            for (int k = 0; k < wlen; k++) begin
               c = ($urandom_range(7) == 0) ? poc_pkg::CHAR_W'($urandom)
                                            : alpha[$urandom_range(1)];
               push_item(poc_pkg::CMD_TEXT, c);
               if ($urandom_range(29) == 0)
                  push_item(poc_pkg::CMD_PATTERN, alpha[$urandom_range(1)]);
            end
         end
         // a missing end of word merges two words
         if (w < nwords - 1 && $urandom_range(7) != 0)
            push_item(poc_pkg::CMD_EOW, poc_pkg::CHAR_W'($urandom));
      end
      if ($urandom_range(1) == 0) push_item(poc_pkg::CMD_EOW, poc_pkg::CHAR_W'($urandom));
      push_item(poc_pkg::CMD_EOT, poc_pkg::CHAR_W'($urandom));
   endtask

   function automatic int idle_percent(input bit receiver);
      int phase;
      phase = (n_accepted * 4) / total_items;
      case (phase)
         1:       return receiver ? 0 : 55;
         2:       return receiver ? 55 : 0;
         3:       return 30;
         default: return 0;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin : drive
      stream_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            count_transaction(req_command, req_char_in);
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_percent(1'b0)) begin
               nxt = pending_items.pop_front();
               req_valid   <= 1'b1;
               req_command <= nxt.cmd;
               req_char_in <= nxt.ch;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : observe
      occurrence_total_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (expected_totals.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("unexpected result: occurrences=%0d overflow=%0b",
                           rsp_occurrences, rsp_pattern_overflow);
            end else begin
               want = expected_totals.pop_front();
               if (rsp_occurrences !== want.occurrences
                   || rsp_pattern_overflow !== want.overflow) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display("mismatch: expected occurrences=%0d overflow=%0b, got %0d %0b",
                              want.occurrences, want.overflow,
                              rsp_occurrences, rsp_pattern_overflow);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= idle_percent(1'b1));
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_counter();
      // end of text with nothing loaded
      push_item(poc_pkg::CMD_EOT, 8'h00);
      // empty pattern, then a pattern byte added mid-word, last word left open
      push_item(poc_pkg::CMD_TEXT, 8'h00);
      push_item(poc_pkg::CMD_EOW, 8'hFF);
      push_item(poc_pkg::CMD_TEXT, 8'hFF);
      push_item(poc_pkg::CMD_PATTERN, 8'h00);
      push_item(poc_pkg::CMD_TEXT, 8'h00);
      push_item(poc_pkg::CMD_EOT, 8'hFF);
      // fill the store and one byte more
      for (int k = 0; k <= MAX_PAT; k++)
         push_item(poc_pkg::CMD_PATTERN, k[0] ? 8'hA5 : 8'h5A);
      push_item(poc_pkg::CMD_TEXT, 8'hA5);
      push_item(poc_pkg::CMD_EOT, 8'h00);
      while (pending_items.size() < 500 || n_text_ends < 20) add_session();
      total_items = pending_items.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted < total_items || expected_totals.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (expected_totals.size() != 0) n_mismatch++;
      $display("sent %0d transactions (%0d end-of-text), checked %0d totals, %0d mismatches",
               n_accepted, n_text_ends, n_results, n_mismatch);
      $display("covered empty, overlapping, late-added and overflowing patterns under stalls");
      if (n_mismatch == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
